// File: rtl/snu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package snu_pkg;

    // default signed coordinate width
    localparam int COORD_WIDTH_DEF = 12;
    // four points, three coordinates each
    localparam int NUM_COORDS      = 12;
    // root digits: q = floor(sqrt(n^2 * 2^30 / m)) never exceeds 2^15
    localparam int ROOT_BITS       = 16;
    // scale of the squared component: (2^14)^2 * 4
    localparam int FRAC_SHIFT      = 30;
    // Q1.14 output width
    localparam int OUT_W           = 16;

endpackage

`default_nettype wire

// File: rtl/surface_normal_unit_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Unit surface normal of a quad (or of a triangle fed as a, a, b, c).
// Slave stream: one item per handshake carries p0..p3, twelve signed
// coordinates of COORD_WIDTH bits packed from the lowest bit up.
// Master stream: norm_x, norm_y, norm_z as signed Q1.14 in tdata, and the
// degenerate flag in tuser (set, with all components zero, when the cross
// product (p2 - p0) x (p3 - p1) vanishes).
// Each magnitude is |n_i| * 16384 / |n| rounded to nearest, ties away from
// zero, exact: a per-component root search finds floor(sqrt(n_i^2*2^30/m)).
// Throughput: one item per cycle while the output item is not held. Pipeline:
// five arithmetic stages, sixteen root digit stages, one output register;
// the root digit pipeline resolves one bit per stage.
// Stall: the whole pipeline holds while the output item waits, so tready
// on the slave side falls only when the output register is full and the
// receiver is not ready; nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) clears all valid bits; data registers
// are not reset.
module surface_normal_unit_core #(
    parameter  int COORD_WIDTH = snu_pkg::COORD_WIDTH_DEF,
    localparam int IN_DW       = ((snu_pkg::NUM_COORDS * COORD_WIDTH + 7) / 8) * 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_s_axis_tvalid,
    output      logic                         o_s_axis_tready,
    // p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z
    input  wire logic [IN_DW-1:0]             i_s_axis_tdata,
    output      logic                         o_m_axis_tvalid,
    input  wire logic                         i_m_axis_tready,
    // norm_x, norm_y, norm_z
    output      logic [3*snu_pkg::OUT_W-1:0]  o_m_axis_tdata,
    // degenerate
    output      logic [0:0]                   o_m_axis_tuser
);
    import snu_pkg::*;

    localparam int W     = COORD_WIDTH;
    localparam int DIF_W = W + 1;
    localparam int PRD_W = 2 * W + 2;
    localparam int N_W   = 2 * W + 3;
    localparam int SQ_W  = 2 * (2 * W + 2);
    localparam int M_W   = SQ_W + 2;
    localparam int S_W   = SQ_W + FRAC_SHIFT;
    localparam int NSTG  = 5 + ROOT_BITS + 1;

    logic            w_en;
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;

    // pipeline advances unless the output item is held
    assign w_en            = ~r_vld[NSTG-1] | i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign n_vld           = {r_vld[NSTG-2:0], i_s_axis_tvalid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= n_vld;
        end
    end

    // stage 1: edge vectors u = p2 - p0, v = p3 - p1
    logic signed [W-1:0]     w_c [NUM_COORDS];
    logic signed [DIF_W-1:0] r1_u [3];
    logic signed [DIF_W-1:0] r1_v [3];

    genvar g;
    generate
        for (g = 0; g < NUM_COORDS; g++) begin : g_unpack
            assign w_c[g] = $signed(i_s_axis_tdata[g*W +: W]);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r1_u[k] <= DIF_W'(w_c[6+k]) - DIF_W'(w_c[k]);
                r1_v[k] <= DIF_W'(w_c[9+k]) - DIF_W'(w_c[3+k]);
            end
        end
    end

    // stage 2: six partial products of the cross product
    logic signed [PRD_W-1:0] r2_p [6];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_p[0] <= PRD_W'(r1_u[1]) * PRD_W'(r1_v[2]);
            r2_p[1] <= PRD_W'(r1_u[2]) * PRD_W'(r1_v[1]);
            r2_p[2] <= PRD_W'(r1_u[2]) * PRD_W'(r1_v[0]);
            r2_p[3] <= PRD_W'(r1_u[0]) * PRD_W'(r1_v[2]);
            r2_p[4] <= PRD_W'(r1_u[0]) * PRD_W'(r1_v[1]);
            r2_p[5] <= PRD_W'(r1_u[1]) * PRD_W'(r1_v[0]);
        end
    end

    // stage 3: cross product n
    logic signed [N_W-1:0] r3_n [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r3_n[k] <= N_W'(r2_p[2*k]) - N_W'(r2_p[2*k+1]);
            end
        end
    end

    // stage 4: squares, signs, degenerate test
    logic signed [2*N_W-1:0] w_sqf [3];
    logic [SQ_W-1:0]         r4_sq [3];
    logic [2:0]              r4_sgn;
    logic                    r4_dg;

    generate
        for (g = 0; g < 3; g++) begin : g_sq
            assign w_sqf[g] = (2*N_W)'(r3_n[g]) * (2*N_W)'(r3_n[g]);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r4_sq[k]  <= w_sqf[k][SQ_W-1:0];
                r4_sgn[k] <= r3_n[k][N_W-1];
            end
            r4_dg <= (r3_n[0] == '0) && (r3_n[1] == '0) && (r3_n[2] == '0);
        end
    end

    // stage 5: squared length m
    logic [M_W-1:0]  r5_m;
    logic [SQ_W-1:0] r5_sq [3];
    logic [2:0]      r5_sgn;
    logic            r5_dg;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_m   <= M_W'(r4_sq[0]) + M_W'(r4_sq[1]) + M_W'(r4_sq[2]);
            r5_sq  <= r4_sq;
            r5_sgn <= r4_sgn;
            r5_dg  <= r4_dg;
        end
    end

    // root search lanes, one per component
    logic [ROOT_BITS-1:0] w_q [3];

    generate
        for (g = 0; g < 3; g++) begin : g_lane
            snu_root #(
                .M_W (M_W),
                .S_W (S_W)
            ) u_root (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_m   (r5_m),
                .i_s   ({r5_sq[g], {FRAC_SHIFT{1'b0}}}),
                .o_q   (w_q[g])
            );
        end
    endgenerate

    // sign and flag ride alongside the root lanes
    logic [2:0] r_sgn_d [ROOT_BITS];
    logic       r_dg_d  [ROOT_BITS];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sgn_d[0] <= r5_sgn;
            r_dg_d[0]  <= r5_dg;
            for (int k = 1; k < ROOT_BITS; k++) begin
                r_sgn_d[k] <= r_sgn_d[k-1];
                r_dg_d[k]  <= r_dg_d[k-1];
            end
        end
    end

    // output: r = (q + 1) / 2, largest r with (2r - 1)^2 m <= n^2 2^30
    logic [ROOT_BITS:0]  w_q1  [3];
    logic [OUT_W-1:0]    w_mag [3];
    logic [OUT_W-1:0]    r_norm [3];
    logic                r_dg;

    generate
        for (g = 0; g < 3; g++) begin : g_out
            assign w_q1[g]  = (ROOT_BITS+1)'(w_q[g]) + (ROOT_BITS+1)'(1);
            assign w_mag[g] = OUT_W'(w_q1[g][ROOT_BITS:1]);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                if (r_dg_d[ROOT_BITS-1]) begin
                    r_norm[k] <= '0;
                end else if (r_sgn_d[ROOT_BITS-1][k]) begin
                    r_norm[k] <= -w_mag[k];
                end else begin
                    r_norm[k] <= w_mag[k];
                end
            end
            r_dg <= r_dg_d[ROOT_BITS-1];
        end
    end

    assign o_m_axis_tvalid = r_vld[NSTG-1];
    assign o_m_axis_tdata  = {r_norm[2], r_norm[1], r_norm[0]};
    assign o_m_axis_tuser  = r_dg;

endmodule

`default_nettype wire

// File: rtl/snu_root.sv
`timescale 1ns / 1ps
`default_nettype none

// One lane of the pipelined root search: q = floor(sqrt(S / M)).
// Each stage tries one bit, from the top. Y holds q * M so that the
// trial term (2q + b) * b * M is only shifts and one add.
module snu_root #(
    parameter int M_W = 54,
    parameter int S_W = 82
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [M_W-1:0]                i_m,
    input  wire logic [S_W-1:0]                i_s,
    output      logic [snu_pkg::ROOT_BITS-1:0] o_q
);
    import snu_pkg::*;

    localparam int RB = ROOT_BITS;
    localparam int DW = M_W + 2 * RB;

    logic [DW-1:0]  w_rem [RB+1];
    logic [DW-1:0]  w_y   [RB+1];
    logic [M_W-1:0] w_m   [RB+1];
    logic [RB-1:0]  w_q   [RB+1];

    logic [DW-1:0]  r_rem [RB];
    logic [DW-1:0]  r_y   [RB];
    logic [M_W-1:0] r_m   [RB];
    logic [RB-1:0]  r_q   [RB];

    assign w_rem[0] = DW'(i_s);
    assign w_y[0]   = '0;
    assign w_m[0]   = i_m;
    assign w_q[0]   = '0;

    genvar j;
    generate
        for (j = 0; j < RB; j++) begin : g_stage
            localparam int K = RB - 1 - j;
            logic [DW-1:0] w_d;
            logic          w_ge;

            // (2q + b) * b * M with b = 2^K
            assign w_d  = (w_y[j] << (K + 1)) + (DW'(w_m[j]) << (2 * K));
            assign w_ge = (w_rem[j] >= w_d);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j] <= w_ge ? (w_rem[j] - w_d) : w_rem[j];
                    r_y[j]   <= w_ge ? (w_y[j] + (DW'(w_m[j]) << K)) : w_y[j];
                    r_m[j]   <= w_m[j];
                    r_q[j]   <= w_q[j] | (RB'(w_ge) << K);
                end
            end

            assign w_rem[j+1] = r_rem[j];
            assign w_y[j+1]   = r_y[j];
            assign w_m[j+1]   = r_m[j];
            assign w_q[j+1]   = r_q[j];
        end
    endgenerate

    assign o_q = w_q[RB];

endmodule

`default_nettype wire

// File: rtl/snu_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module snu_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_s_axis_tready,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [47:0] o_m_axis_tdata,
    input wire logic [0:0]  o_m_axis_tuser
);

    // held output item keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("output item changed while stalled");

    // input side only blocks when the output register is held
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready == (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("tready does not follow output stall");

    // degenerate items carry an all-zero normal
    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tdata == 48'd0)
        else $error("degenerate item with nonzero normal");

    // components stay within one in Q1.14
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ($signed(o_m_axis_tdata[15:0])  <= 16384 &&
             $signed(o_m_axis_tdata[15:0])  >= -16384 &&
             $signed(o_m_axis_tdata[31:16]) <= 16384 &&
             $signed(o_m_axis_tdata[31:16]) >= -16384 &&
             $signed(o_m_axis_tdata[47:32]) <= 16384 &&
             $signed(o_m_axis_tdata[47:32]) >= -16384))
        else $error("normal component out of range");

endmodule

bind surface_normal_unit_core snu_chk u_snu_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire

// File: test/normal_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module normal_checker #(
    parameter int COORD_WIDTH = snu_pkg::COORD_WIDTH_DEF,
    parameter int IN_DW       = ((snu_pkg::NUM_COORDS * COORD_WIDTH + 7) / 8) * 8
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    input  wire logic                             i_s_tready,
    input  wire logic [IN_DW-1:0]                 i_s_tdata,
    input  wire logic                             i_m_tvalid,
    input  wire logic                             i_m_tready,
    input  wire logic [3*snu_pkg::OUT_W-1:0]      i_m_tdata,
    input  wire logic [0:0]                       i_m_tuser,
    output      int                               o_fail_count,
    output      int                               o_pending,
    output      int                               o_checked,
    output      int                               o_degenerate_seen
);

    typedef struct packed {
        logic signed [snu_pkg::OUT_W-1:0] nx;
        logic signed [snu_pkg::OUT_W-1:0] ny;
        logic signed [snu_pkg::OUT_W-1:0] nz;
        logic                             degen;
    } normal_t;

    normal_t pending_normals[$];

    // largest r in 0..16384 with (2r-1)^2 * m <= n^2 * 2^30, sign of n kept
    function automatic logic [snu_pkg::OUT_W-1:0] unit_component(longint n,
                                                                logic [127:0] m);
        logic [63:0]  mag;
        logic [127:0] rhs;
        logic [127:0] t;
        int           lo;
        int           hi;
        int           mid;
        mag = (n < 0) ? 64'(-n) : 64'(n);
        rhs = ({64'd0, mag} * {64'd0, mag}) << snu_pkg::FRAC_SHIFT;
        lo  = 0;
        hi  = 16384;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            t   = 128'(2 * mid - 1);
            if (m * t * t <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return (n < 0) ? -(snu_pkg::OUT_W'(lo)) : snu_pkg::OUT_W'(lo);
    endfunction

    function automatic normal_t predict_normal(logic [IN_DW-1:0] d);
        longint       c[snu_pkg::NUM_COORDS];
        longint       ux, uy, uz, vx, vy, vz, cx, cy, cz;
        logic [127:0] m;
        normal_t      r;
        for (int i = 0; i < snu_pkg::NUM_COORDS; i++)
            c[i] = longint'($signed(d[i*COORD_WIDTH +: COORD_WIDTH]));
        ux = c[6] - c[0];
        uy = c[7] - c[1];
        uz = c[8] - c[2];
        vx = c[9] - c[3];
        vy = c[10] - c[4];
        vz = c[11] - c[5];
        cx = uy * vz - uz * vy;
        cy = uz * vx - ux * vz;
        cz = ux * vy - uy * vx;
        if (cx == 0 && cy == 0 && cz == 0) begin
            r = '{nx: '0, ny: '0, nz: '0, degen: 1'b1};
        end else begin
            // squares are non-negative; fits well within 64 bits, widen anyway
            m = 128'(cx * cx) + 128'(cy * cy) + 128'(cz * cz);
            r.nx    = unit_component(cx, m);
            r.ny    = unit_component(cy, m);
            r.nz    = unit_component(cz, m);
            r.degen = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH item %0d: %s got %0d expected %0d", o_checked, what, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count      = 0;
        o_checked         = 0;
        o_degenerate_seen = 0;
    end

    assign o_pending = pending_normals.size();

    always @(posedge i_clk) begin
        normal_t want;
        normal_t got;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready)
                pending_normals.push_back(predict_normal(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got = '{nx: i_m_tdata[15:0], ny: i_m_tdata[31:16],
                        nz: i_m_tdata[47:32], degen: i_m_tuser[0]};
                if (pending_normals.size() == 0) begin
                    $display("UNEXPECTED result with nothing outstanding");
                    o_fail_count++;
                end else begin
                    want = pending_normals.pop_front();
                    if (got.nx !== want.nx) report_mismatch("norm_x", got.nx, want.nx);
                    if (got.ny !== want.ny) report_mismatch("norm_y", got.ny, want.ny);
                    if (got.nz !== want.nz) report_mismatch("norm_z", got.nz, want.nz);
                    if (got.degen !== want.degen)
                        report_mismatch("degenerate", got.degen, want.degen);
                    if (want.degen) o_degenerate_seen++;
                end
                o_checked++;
            end
        end
    end

endmodule

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps
`default_nettype none

module tb;

    localparam int CW        = snu_pkg::COORD_WIDTH_DEF;
    localparam int IN_DW     = ((snu_pkg::NUM_COORDS * CW + 7) / 8) * 8;
    localparam int LATENCY   = 22;
    localparam int CYCLE_CAP = 400000;
    localparam int HOLD_LEN  = 300;

    typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH, PH_HOLD} phase_t;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [IN_DW-1:0]             s_tdata;       // p0_x .. p3_z, 12 bits each, low first
    logic                         m_tvalid;
    logic                         m_tready;
    logic [3*snu_pkg::OUT_W-1:0]  m_tdata;       // norm_x, norm_y, norm_z
    logic [0:0]                   m_tuser;       // degenerate

    int     fails, pending, checked, degen_seen;
    int     cycles;
    int     sent;
    phase_t phase;
    bit     hold_done;

    surface_normal_unit_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    normal_checker #(.COORD_WIDTH(CW)) i_chk (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_s_tvalid        (s_tvalid),
        .i_s_tready        (s_tready),
        .i_s_tdata         (s_tdata),
        .i_m_tvalid        (m_tvalid),
        .i_m_tready        (m_tready),
        .i_m_tdata         (m_tdata),
        .i_m_tuser         (m_tuser),
        .o_fail_count      (fails),
        .o_pending         (pending),
        .o_checked         (checked),
        .o_degenerate_seen (degen_seen)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // watchdog
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: stalls per phase; one long hold-off so the pipe backs up
    initial begin
        m_tready  = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (phase == PH_HOLD && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
                hold_done = 1'b1;
                m_tready <= 1'b1;
            end else if (phase == PH_RECV_STALL) begin
                m_tready <= ($urandom_range(99) >= 67);
            end else if (phase == PH_BOTH) begin
                m_tready <= ($urandom_range(99) >= 19);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // one item: optional idle gap, then hold tvalid until accepted
    task automatic send_item(logic signed [CW-1:0] c[12]);
        int idle_pct;
        idle_pct = (phase == PH_SEND_IDLE) ? 67 : (phase == PH_BOTH) ? 19 : 0;
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        for (int i = 0; i < 12; i++)
            s_tdata[i*CW +: CW] <= c[i];
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        sent++;
    endtask

    task automatic send_points(int a0, a1, a2, b0, b1, b2, c0, c1, c2, d0, d1, d2);
        logic signed [CW-1:0] c[12];
        c = '{CW'(a0), CW'(a1), CW'(a2), CW'(b0), CW'(b1), CW'(b2),
              CW'(c0), CW'(c1), CW'(c2), CW'(d0), CW'(d1), CW'(d2)};
        send_item(c);
    endtask

    function automatic int rnd_coord(int span);
        return $urandom_range(2 * span) - span;
    endfunction

    // mix: full-range, small-range, triangles, parallel-diagonal (degenerate) sets
    task automatic send_random();
        logic signed [CW-1:0] c[12];
        int kind, dx, dy, dz, k;
        kind = $urandom_range(9);
        if (kind < 4) begin
            for (int i = 0; i < 12; i++) c[i] = CW'($urandom);
        end else if (kind < 6) begin
            for (int i = 0; i < 12; i++) c[i] = CW'(rnd_coord(8));
        end else if (kind < 8) begin
            // triangle a, a, b, c
            for (int i = 0; i < 12; i++) c[i] = CW'($urandom);
            for (int i = 0; i < 3; i++) c[3 + i] = c[i];
        end else begin
            // parallel diagonals give a zero cross product
            dx = rnd_coord(60); dy = rnd_coord(60); dz = rnd_coord(60);
            k  = rnd_coord(15);
            for (int i = 0; i < 6; i++) c[i] = CW'(rnd_coord(900));
            c[6] = CW'(int'(c[0]) + dx);     c[7]  = CW'(int'(c[1]) + dy);
            c[8] = CW'(int'(c[2]) + dz);     c[9]  = CW'(int'(c[3]) + k * dx);
            c[10] = CW'(int'(c[4]) + k * dy); c[11] = CW'(int'(c[5]) + k * dz);
        end
        send_item(c);
    endtask

    initial begin
        phase    = PH_FREE;
        sent     = 0;
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: degenerate, axis-aligned both signs, extremes, triangles
        send_points(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_points(5, 5, 5, -3, 7, 1, 5, 5, 5, 9, 9, 9);
        send_points(0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0);
        send_points(0, 0, 0, 0, 0, 0, 0, 1, 0, 1, 0, 0);
        send_points(0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1);
        send_points(0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1, 0);
        send_points(0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0);
        send_points(0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1);
        send_points(-2048, -2048, -2048, -2048, -2048, -2048,
                    2047, -2048, -2048, -2048, 2047, -2048);
        send_points(2047, 2047, 2047, 2047, 2047, 2047,
                    -2048, -2048, 2047, 2047, -2048, -2048);
        send_points(-2048, 2047, -2048, 2047, -2048, 2047,
                    2047, -2048, 2047, -2048, 2047, -2048);
        send_points(-2048, -2048, 0, 2047, -2048, 0, 2047, 2047, 0, -2048, 2047, 0);
        send_points(1, 2, 3, 1, 2, 3, 4, 6, 3, 1, 2, 9);
        send_points(-100, 50, 7, -100, 50, 7, 300, -20, 11, 40, 900, -600);
        send_points(0, 0, 0, 0, 0, 0, 1, 1, 1, 1, 0, 0);
        send_points(0, 0, 0, 0, 0, 0, 3, 4, 0, 0, 0, 1);
        send_points(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1);

        for (int n = 0; n < 900; n++) begin
            case (n / 150)
                0: phase = PH_FREE;
                1: phase = PH_SEND_IDLE;
                2: phase = PH_RECV_STALL;
                3: phase = PH_BOTH;
                4: phase = PH_HOLD;
                default: phase = (n % 40 < 20) ? PH_FREE : PH_BOTH;
            endcase
            send_random();
        end
        s_tvalid <= 1'b0;
        phase = PH_FREE;

        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);

        $display("Sent %0d items, checked %0d normals (%0d degenerate), across idle,",
                 sent, checked, degen_seen);
        $display("stall, mixed and long back-pressure phases; %0d mismatches", fails);
        if (fails == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
